### hw/rtl/motor_command_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor command frame builder
// Two concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_BUILDER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold at a clock edge outside reset
`define MCFB_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("mcfb check failed");

// whenever ante holds, cons holds in the same cycle
`define MCFB_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("mcfb check failed");

`else

`define MCFB_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`define MCFB_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### hw/rtl/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// mcfb_pkg
// Types, constants and helper functions of the motor command frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfb_pkg;

	typedef enum logic [2:0] {
		CMD_DUTY    = 3'd0,
		CMD_CURRENT = 3'd1,
		CMD_BRAKE   = 3'd2,
		CMD_SERVO   = 3'd3,
		CMD_ALIVE   = 3'd4
	} cmd_e;

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	localparam logic [7:0] OP_DUTY    = 8'd5;
	localparam logic [7:0] OP_CURRENT = 8'd6;
	localparam logic [7:0] OP_BRAKE   = 8'd7;
	localparam logic [7:0] OP_SERVO   = 8'd12;
	localparam logic [7:0] OP_ALIVE   = 8'd30;

	localparam int SCALE_W = 17;
	localparam logic [SCALE_W-1:0] DUTY_SCALE = 17'd100000;
	localparam logic [SCALE_W-1:0] AMP_SCALE  = 17'd1000;
	localparam logic [SCALE_W-1:0] SERVO_SCALE = 17'd1000;

	localparam logic signed [31:0] Q_ONE     = 32'sd65536;
	localparam logic signed [31:0] Q_NEG_ONE = -32'sd65536;
	localparam int Q_FRAC = 16;

	// |value| < 2^31 times scale <= 2^17 still fits in 43 signed bits here:
	// duty is clamped to one, currents use scale 1000 (< 2^10)
	localparam int PROD_W = 43;
	localparam int MUL_W  = 32 + SCALE_W + 1;

	localparam int JQ_DEPTH = 4;
	localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} out_item_t;

	// one frame's worth of work between front and back
	typedef struct packed {
		logic [7:0]  opcode;
		logic [2:0]  plen;
		logic [31:0] arg;
	} job_t;

	typedef struct packed {
		logic [JQ_CNT_W-1:0] count;
		logic                empty;
	} jq_stat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/motor_command_frame_builder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder: commands pass two front stages and the job queue to the back end.
// One byte per cycle while popped; frames: 10 (duty, currents), 8 (servo), 6 (keep-alive) bytes.
// Commands are taken one per cycle while fewer than 4 sit in the two stages and job queue.
// arst_n clears all queues and the link enable (link off); no frame survives reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_command_frame_builder_macros.svh"

module motor_command_frame_builder (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command side
	input  wire logic                  push,
	output logic                       full,
	input  wire mcfb_pkg::in_item_t    item,
	// frame byte side
	output logic                       empty,
	input  wire logic                  pop,
	output mcfb_pkg::out_item_t        result,
	// register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	// Register map: link_enable at byte offset 0, bit 0. Offsets with bit 2
	// set hold nothing; writes there are dropped and reads return zero.
	logic link_enable_q;
	logic reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_enable_q <= 1'b0;
		end else if (reg_wr) begin
			link_enable_q <= pwdata[0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {31'd0, link_enable_q};

	// Front: classification, clamp, multiply and truncating shift. Items for
	// a disabled link or an unknown command are taken and then dropped.
	logic               q_push;
	logic               q_pop;
	mcfb_pkg::job_t     q_wr_job;
	mcfb_pkg::job_t     q_rd_job;
	mcfb_pkg::jq_stat_t q_stat;

	mcfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.link_enable (link_enable_q),
		.push        (push),
		.full        (full),
		.item        (item),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_job       (q_wr_job)
	);

	// Job queue: the front only launches work when a slot is reserved, so
	// writes never meet a full queue.
	mcfb_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wr_job),
		.rd      (q_pop),
		.rd_data (q_rd_job),
		.stat    (q_stat)
	);

	// Back: walks start, length, opcode, argument, CRC high/low, end byte;
	// the CRC runs over opcode and argument bytes as they go out.
	mcfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (q_rd_job),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	// Queue occupancy never passes its depth.
	`MCFB_ASSERT_NEVER(a_jq_bound, clk, arst_n, q_stat.count > mcfb_pkg::JQ_CNT_W'(mcfb_pkg::JQ_DEPTH))

	// The credit scheme keeps the front from writing a full queue.
	`MCFB_ASSERT_NEVER(a_jq_no_overrun, clk, arst_n, q_push && !q_pop && (q_stat.count == mcfb_pkg::JQ_CNT_W'(mcfb_pkg::JQ_DEPTH)))

	// The back end never pops an empty queue.
	`MCFB_ASSERT_NEVER(a_jq_no_underrun, clk, arst_n, q_pop && q_stat.empty)

	// The byte flagged last is always the end byte.
	`MCFB_ASSERT_IMPLIES(a_last_is_end, clk, arst_n, !empty && result.last, result.frame_byte == mcfb_pkg::END_BYTE)

endmodule

`default_nettype wire

### hw/rtl/mcfb_front.sv
// ----------------------------------------------------------------------------
// mcfb_front
// Accepts commands, drops unknown ones and any taken while the link is off, clamps and scales the argument.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfb_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       link_enable,
	input  wire logic                       push,
	output logic                            full,
	input  wire mcfb_pkg::in_item_t         item,
	input  wire mcfb_pkg::jq_stat_t         q_stat,
	output logic                            q_push,
	output mcfb_pkg::job_t                  q_job
);

	logic                               v_s1, v_s2;
	logic [7:0]                         op_s1, op_s2;
	logic [2:0]                         plen_s1, plen_s2;
	logic signed [31:0]                 val_s1;
	logic [mcfb_pkg::SCALE_W-1:0]       scale_s1;
	logic signed [mcfb_pkg::PROD_W-1:0] prod_s2;

	logic                               take;
	logic                               known;
	logic [7:0]                         op_d;
	logic [2:0]                         plen_d;
	logic signed [31:0]                 val_d;
	logic [mcfb_pkg::SCALE_W-1:0]       scale_d;
	logic signed [mcfb_pkg::MUL_W-1:0]  mul;
	logic signed [mcfb_pkg::PROD_W-1:0] adj;
	logic [mcfb_pkg::JQ_CNT_W+1:0]      pending;

	// credit: queue entries plus items still in the two stages
	assign pending = (mcfb_pkg::JQ_CNT_W+2)'(q_stat.count)
		+ (mcfb_pkg::JQ_CNT_W+2)'(v_s1) + (mcfb_pkg::JQ_CNT_W+2)'(v_s2);
	assign full = (pending >= (mcfb_pkg::JQ_CNT_W+2)'(mcfb_pkg::JQ_DEPTH));
	assign take = push && !full;

	always_comb begin
		known   = 1'b1;
		op_d    = mcfb_pkg::OP_ALIVE;
		plen_d  = 3'd1;
		val_d   = item.value;
		scale_d = '0;
		unique case (item.cmd)
			mcfb_pkg::CMD_DUTY: begin
				op_d    = mcfb_pkg::OP_DUTY;
				plen_d  = 3'd5;
				scale_d = mcfb_pkg::DUTY_SCALE;
				if (item.value > mcfb_pkg::Q_ONE) begin
					val_d = mcfb_pkg::Q_ONE;
				end else if (item.value < mcfb_pkg::Q_NEG_ONE) begin
					val_d = mcfb_pkg::Q_NEG_ONE;
				end
			end
			mcfb_pkg::CMD_CURRENT: begin
				op_d    = mcfb_pkg::OP_CURRENT;
				plen_d  = 3'd5;
				scale_d = mcfb_pkg::AMP_SCALE;
			end
			mcfb_pkg::CMD_BRAKE: begin
				op_d    = mcfb_pkg::OP_BRAKE;
				plen_d  = 3'd5;
				scale_d = mcfb_pkg::AMP_SCALE;
			end
			mcfb_pkg::CMD_SERVO: begin
				op_d    = mcfb_pkg::OP_SERVO;
				plen_d  = 3'd3;
				scale_d = mcfb_pkg::SERVO_SCALE;
				if (item.value > mcfb_pkg::Q_ONE) begin
					val_d = mcfb_pkg::Q_ONE;
				end else if (item.value < 32'sd0) begin
					val_d = 32'sd0;
				end
			end
			mcfb_pkg::CMD_ALIVE: begin
				op_d   = mcfb_pkg::OP_ALIVE;
				plen_d = 3'd1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign mul = val_s1 * $signed({1'b0, scale_s1});

	// divide by 2^16 truncating toward zero: bias negatives before the shift
	assign adj = prod_s2 + (prod_s2[mcfb_pkg::PROD_W-1]
		? mcfb_pkg::PROD_W'(65535) : mcfb_pkg::PROD_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && known && link_enable;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= op_d;
		plen_s1  <= plen_d;
		val_s1   <= val_d;
		scale_s1 <= scale_d;
		op_s2    <= op_s1;
		plen_s2  <= plen_s1;
		prod_s2  <= mul[mcfb_pkg::PROD_W-1:0];
	end

	assign q_push       = v_s2;
	assign q_job.opcode = op_s2;
	assign q_job.plen   = plen_s2;
	assign q_job.arg    = 32'(adj[mcfb_pkg::PROD_W-1:mcfb_pkg::Q_FRAC])
		| ({32{adj[mcfb_pkg::PROD_W-1]}} << (mcfb_pkg::PROD_W - mcfb_pkg::Q_FRAC));

endmodule

`default_nettype wire

### hw/rtl/mcfb_jobq.sv
// ----------------------------------------------------------------------------
// mcfb_jobq
// Short FIFO of frame jobs between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfb_jobq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire mcfb_pkg::job_t     wr_data,
	input  wire logic               rd,
	output mcfb_pkg::job_t          rd_data,
	output mcfb_pkg::jq_stat_t      stat
);

	mcfb_pkg::job_t                  mem_q [mcfb_pkg::JQ_DEPTH];
	logic [mcfb_pkg::JQ_PTR_W-1:0]   wp_q, rp_q;
	logic [mcfb_pkg::JQ_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + mcfb_pkg::JQ_CNT_W'(wr) - mcfb_pkg::JQ_CNT_W'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rp_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

### hw/rtl/mcfb_back.sv
// ----------------------------------------------------------------------------
// mcfb_back
// Serializes one job into frame bytes with a running CRC, two-entry output.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfb_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mcfb_pkg::job_t     q_data,
	input  wire mcfb_pkg::jq_stat_t q_stat,
	output logic                    q_pop,
	input  wire logic               pop,
	output logic                    empty,
	output mcfb_pkg::out_item_t     result
);

	logic                  active_q;
	mcfb_pkg::job_t        job_q;
	logic [3:0]            idx_q;
	logic [15:0]           crc_q;

	mcfb_pkg::out_item_t   ob_q [2];
	logic                  ob_wp_q, ob_rp_q;
	logic [1:0]            ob_cnt_q;

	logic                  pop_ok, space, emit, is_last, is_pay;
	logic [3:0]            pay_end;
	logic [2:0]            k, sh;
	logic [7:0]            pay_byte;
	mcfb_pkg::out_item_t   nb;

	assign pop_ok  = pop && (ob_cnt_q != 2'd0);
	assign space   = (ob_cnt_q != 2'd2) || pop_ok;
	assign emit    = active_q && space;

	assign pay_end  = {1'b0, job_q.plen} + 4'd2;
	assign k        = 3'(idx_q - 4'd2);
	assign sh       = job_q.plen - 3'd1 - k;
	assign pay_byte = 8'(job_q.arg >> {sh[1:0], 3'b000});
	assign is_pay   = (idx_q >= 4'd2) && (idx_q < pay_end);
	assign is_last  = (idx_q == pay_end + 4'd2);

	always_comb begin
		nb.last = 1'b0;
		if (idx_q == 4'd0) begin
			nb.frame_byte = mcfb_pkg::START_BYTE;
		end else if (idx_q == 4'd1) begin
			nb.frame_byte = {5'd0, job_q.plen};
		end else if (idx_q == 4'd2) begin
			nb.frame_byte = job_q.opcode;
		end else if (is_pay) begin
			nb.frame_byte = pay_byte;
		end else if (idx_q == pay_end) begin
			nb.frame_byte = crc_q[15:8];
		end else if (idx_q == pay_end + 4'd1) begin
			nb.frame_byte = crc_q[7:0];
		end else begin
			nb.frame_byte = mcfb_pkg::END_BYTE;
			nb.last       = 1'b1;
		end
	end

	// next job loads as the current one sends its end byte
	assign q_pop = !q_stat.empty && (!active_q || (emit && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			crc_q    <= '0;
		end else if (q_pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			crc_q    <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
			if (is_last) begin
				active_q <= 1'b0;
			end
			if (is_pay) begin
				crc_q <= mcfb_pkg::crc_byte(crc_q, nb.frame_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (emit) begin
			ob_q[ob_wp_q] <= nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (emit) begin
				ob_wp_q <= ~ob_wp_q;
			end
			if (pop_ok) begin
				ob_rp_q <= ~ob_rp_q;
			end
			ob_cnt_q <= ob_cnt_q + 2'(emit) - 2'(pop_ok);
		end
	end

	assign empty  = (ob_cnt_q == 2'd0);
	assign result = ob_q[ob_rp_q];

endmodule

`default_nettype wire

### test/mcfb_frame_checker.sv
// ----------------------------------------------------------------------------
// mcfb_frame_checker
// Watches the command, frame byte and register channels of the frame builder,
// predicts every frame byte from each command transfer and compares it with
// the bytes that leave the block, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfb_frame_checker #(
	parameter logic [2:0] LINK_ADDR = '0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  full,
	input  wire mcfb_pkg::in_item_t    item,
	input  wire logic                  empty,
	input  wire logic                  pop,
	input  wire mcfb_pkg::out_item_t   result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	input  wire logic                  pready,
	output int                         mismatches,
	output int                         bytes_due
);

	localparam logic [7:0]  FRAME_START  = 8'h02;
	localparam logic [7:0]  FRAME_END    = 8'h03;
	localparam logic [15:0] XMODEM_POLY  = 16'h1021;
	localparam logic [7:0]  OPC_DUTY     = 8'd5;
	localparam logic [7:0]  OPC_CURRENT  = 8'd6;
	localparam logic [7:0]  OPC_BRAKE    = 8'd7;
	localparam logic [7:0]  OPC_SERVO    = 8'd12;
	localparam logic [7:0]  OPC_ALIVE    = 8'd30;
	localparam longint      Q_UNIT       = 65536;
	localparam longint      DUTY_GAIN    = 100000;
	localparam longint      AMP_GAIN     = 1000;
	localparam longint      SERVO_GAIN   = 1000;

	logic                  link_on;
	mcfb_pkg::out_item_t   frame_bytes_due [$];

	task automatic report_mismatch(input string what);
		$display("%0t mcfb_frame_checker: %s", $realtime, what);
		mismatches++;
	endtask

	// bit-serial CRC-16/XMODEM, MSB first
	function automatic logic [15:0] xmodem_update(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int b = 7; b >= 0; b--) begin
			fb = r[15] ^ data[b];
			r  = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ XMODEM_POLY;
			end
		end
		return r;
	endfunction

	function automatic void queue_byte(input logic [7:0] data, input logic is_last);
		mcfb_pkg::out_item_t b;
		b.frame_byte = data;
		b.last       = is_last;
		frame_bytes_due.push_back(b);
	endfunction

	function automatic void predict_frame(input mcfb_pkg::in_item_t cmd_in);
		longint      arg;
		longint      scaled;
		logic [7:0]  payload [5];
		int          plen;
		logic [15:0] crc;
		arg    = longint'($signed(cmd_in.value));
		scaled = 0;
		plen   = 0;
		foreach (payload[i]) begin
			payload[i] = '0;
		end
		if (!link_on) begin
			return;
		end
		case (cmd_in.cmd)
			mcfb_pkg::CMD_DUTY: begin
				if (arg > Q_UNIT) begin
					arg = Q_UNIT;
				end
				if (arg < -Q_UNIT) begin
					arg = -Q_UNIT;
				end
				scaled     = arg * DUTY_GAIN / Q_UNIT;
				payload[0] = OPC_DUTY;
				plen       = 5;
			end
			mcfb_pkg::CMD_CURRENT, mcfb_pkg::CMD_BRAKE: begin
				scaled     = arg * AMP_GAIN / Q_UNIT;
				payload[0] = (cmd_in.cmd == mcfb_pkg::CMD_CURRENT) ? OPC_CURRENT : OPC_BRAKE;
				plen       = 5;
			end
			mcfb_pkg::CMD_SERVO: begin
				if (arg > Q_UNIT) begin
					arg = Q_UNIT;
				end
				if (arg < 0) begin
					arg = 0;
				end
				scaled     = arg * SERVO_GAIN / Q_UNIT;
				payload[0] = OPC_SERVO;
				plen       = 3;
			end
			mcfb_pkg::CMD_ALIVE: begin
				payload[0] = OPC_ALIVE;
				plen       = 1;
			end
			default: begin
				return;
			end
		endcase
		if (plen == 5) begin
			payload[1] = scaled[31:24];
			payload[2] = scaled[23:16];
			payload[3] = scaled[15:8];
			payload[4] = scaled[7:0];
		end else if (plen == 3) begin
			payload[1] = scaled[15:8];
			payload[2] = scaled[7:0];
		end
		crc = '0;
		queue_byte(FRAME_START, 1'b0);
		queue_byte(8'(plen), 1'b0);
		for (int k = 0; k < plen; k++) begin
			queue_byte(payload[k], 1'b0);
			crc = xmodem_update(crc, payload[k]);
		end
		queue_byte(crc[15:8], 1'b0);
		queue_byte(crc[7:0], 1'b0);
		queue_byte(FRAME_END, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mcfb_pkg::out_item_t want;
		if (!arst_n) begin
			link_on    = 1'b0;
			mismatches = 0;
			bytes_due  = 0;
			frame_bytes_due.delete();
		end else begin
			// only bit 0 of register 0 is kept; register index is address bit 2
			if (psel && penable && pwrite && pready && paddr[2] == LINK_ADDR[2]) begin
				link_on = pwdata[0];
			end
			if (push && !full) begin
				predict_frame(item);
			end
			if (pop && !empty) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						result.frame_byte, result.last));
				end else begin
					want = frame_bytes_due.pop_front();
					if (result.frame_byte !== want.frame_byte) begin
						report_mismatch($sformatf("frame_byte %02h, expected %02h",
							result.frame_byte, want.frame_byte));
					end
					if (result.last !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
							result.last, want.last, want.frame_byte));
					end
				end
			end
			bytes_due = frame_bytes_due.size();
		end
	end

endmodule

`default_nettype wire

### test/motor_command_frame_builder_test.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder_test
// Drives commands and link enable writes into the frame builder under several
// idle and stall patterns; a checker beside the block predicts each frame and
// compares it byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_command_frame_builder_test;

	// register map: link_enable at index 0, index 1 is unmapped
	localparam logic [2:0] LINK_ENABLE_ADDR = 3'd0;
	localparam logic [2:0] UNMAPPED_ADDR    = 3'd4;

	localparam int ITEMS_LINK_ON  = 110;
	localparam int ITEMS_LINK_OFF = 15;
	localparam int DRAIN_CYCLES   = 64;     // job queue + stages + longest frame, with margin
	localparam int SETTLE_LIMIT   = 50000;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	mcfb_pkg::in_item_t    item;
	logic                  empty;
	logic                  pop;
	mcfb_pkg::out_item_t   result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int                    mismatches;
	int                    bytes_due;

	// idle rates in percent, changed per phase
	int unsigned           send_gap_pct;
	int unsigned           pop_stall_pct;

	motor_command_frame_builder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mcfb_frame_checker #(
		.LINK_ADDR (LINK_ENABLE_ADDR)
	) frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the block hangs; well above the slowest legal run
	initial begin
		#2000000;
		$display("motor_command_frame_builder_test: errors");
		$finish;
	end

	// frame byte side: pop redrawn every falling edge, stalling at the phase rate
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(0, 99) >= pop_stall_pct);
		end
	end

	// one command transfer; push is left high so back-to-back transfers need no gap
	task automatic send(input logic [2:0] code, input logic signed [31:0] arg);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < send_gap_pct) begin
				@(negedge clk);
			end
		end
		push       <= 1'b1;
		item.cmd   <= code;
		item.value <= arg;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// drop push, wait for the last predicted byte, then let ignored commands drain
	task automatic settle();
		int unsigned waited;
		waited = 0;
		push <= 1'b0;
		while (bytes_due != 0 && waited < SETTLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup phase, then access until pready
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Q16.16 arguments: mostly around the clamp points, some full range and extremes
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 4 * 65536) - 2 * 65536;
			3: return $urandom_range(0, 65536);
			4: return $urandom_range(0, 31) - 16;
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 65536;
					3: return -65536;
					4: return 65537;
					default: return -65537;
				endcase
			end
		endcase
	endfunction

	// valid commands most of the time, unknown codes about one in ten
	function automatic logic [2:0] pick_cmd();
		if ($urandom_range(0, 9) == 0) begin
			return 3'(mcfb_pkg::CMD_ALIVE) + 3'($urandom_range(1, 3));
		end
		return 3'($urandom_range(0, int'(mcfb_pkg::CMD_ALIVE)));
	endfunction

	initial begin
		int unsigned gap_modes   [4];
		int unsigned stall_modes [4];
		gap_modes   = '{0, 79, 0, 15};
		stall_modes = '{0, 0, 79, 15};

		arst_n        = 1'b0;
		push          = 1'b0;
		item          = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_gap_pct  = 0;
		pop_stall_pct = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// link is off out of reset: every code, including unknown ones, must stay silent
		for (int c = 0; c < 8; c++) begin
			send(3'(c), $urandom);
		end
		settle();

		// enable with junk in the upper bits; the unmapped write must not disturb it
		write_reg(LINK_ENABLE_ADDR, $urandom | 32'h1);
		write_reg(UNMAPPED_ADDR, 32'h0);

		// duty: zero, clamp edges on both sides, range extremes, rounding toward zero
		send(mcfb_pkg::CMD_DUTY, 0);
		send(mcfb_pkg::CMD_DUTY, 65536);
		send(mcfb_pkg::CMD_DUTY, 65537);
		send(mcfb_pkg::CMD_DUTY, -65536);
		send(mcfb_pkg::CMD_DUTY, -65537);
		send(mcfb_pkg::CMD_DUTY, 32'sh7fffffff);
		send(mcfb_pkg::CMD_DUTY, 32'sh80000000);
		send(mcfb_pkg::CMD_DUTY, 1);
		send(mcfb_pkg::CMD_DUTY, -1);
		// currents are unclamped, so the full range goes straight through scaling
		send(mcfb_pkg::CMD_CURRENT, 32'sh7fffffff);
		send(mcfb_pkg::CMD_CURRENT, 32'sh80000000);
		send(mcfb_pkg::CMD_CURRENT, -1);
		send(mcfb_pkg::CMD_CURRENT, $urandom);
		send(mcfb_pkg::CMD_BRAKE, -65536);
		send(mcfb_pkg::CMD_BRAKE, 32'sh7fffffff);
		// servo: negatives clamp to zero, above one clamps to one
		send(mcfb_pkg::CMD_SERVO, -1);
		send(mcfb_pkg::CMD_SERVO, 0);
		send(mcfb_pkg::CMD_SERVO, 65536);
		send(mcfb_pkg::CMD_SERVO, 65537);
		send(mcfb_pkg::CMD_SERVO, 32'sh80000000);
		send(mcfb_pkg::CMD_SERVO, 32767);
		// keep-alive ignores its argument
		send(mcfb_pkg::CMD_ALIVE, 0);
		send(mcfb_pkg::CMD_ALIVE, $urandom);
		// unknown codes above keep-alive are dropped
		for (int c = int'(mcfb_pkg::CMD_ALIVE) + 1; c < 8; c++) begin
			send(3'(c), $urandom);
		end
		settle();

		// random phases: each idle pattern with the link on, then a short burst with it off
		foreach (gap_modes[m]) begin
			send_gap_pct  = gap_modes[m];
			pop_stall_pct = stall_modes[m];
			write_reg(LINK_ENABLE_ADDR, $urandom | 32'h1);
			for (int i = 0; i < ITEMS_LINK_ON; i++) begin
				send(pick_cmd(), pick_value());
			end
			settle();
			write_reg(LINK_ENABLE_ADDR, $urandom & ~32'h1);
			for (int i = 0; i < ITEMS_LINK_OFF; i++) begin
				send(pick_cmd(), pick_value());
			end
			settle();
		end

		if (mismatches == 0 && bytes_due == 0) begin
			$display("motor_command_frame_builder_test: clean");
		end else begin
			$display("motor_command_frame_builder_test: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/mcfb_pkg.sv
hw/rtl/mcfb_front.sv
hw/rtl/mcfb_jobq.sv
hw/rtl/mcfb_back.sv
hw/rtl/motor_command_frame_builder.sv
test/mcfb_frame_checker.sv
test/motor_command_frame_builder_test.sv
